>>> hdl/emgwdc_pkg.sv
package emgwdc_pkg;

  // Frame geometry.
  localparam int unsigned NCH        = 8;
  localparam int unsigned MAG_W      = 8;
  localparam int unsigned MAG_MAX    = 128;
  localparam int unsigned SAMPLE_W   = 8;

  // Default window length in frames.
  localparam int unsigned WINDOW_DEF = 20;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_W      = 10;

  localparam logic [CFG_IDX_W-1:0] REG_REST_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_GAIN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAIN     = 2'd2;

  localparam logic [CFG_W-1:0] RESET_REST_THRESHOLD = 10'd5;
  localparam logic [CFG_W-1:0] RESET_UP_GAIN        = 10'd384;
  localparam logic [CFG_W-1:0] RESET_RIGHT_GAIN     = 10'd691;

  // Divider widths: the largest dividend is an 8 by 10 bit product, the
  // largest divisor is 1 + 128 + 128.
  localparam int unsigned DIV_W  = 18;
  localparam int unsigned DIVR_W = 9;

  // Width of the score sum and the rest limit.
  localparam int unsigned TOT_W  = 20;

  // Direction codes.
  localparam int unsigned DIR_W = 3;
  localparam logic [DIR_W-1:0] DIR_REST  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd4;

  // Division operations. Codes below OP_UP are the channel means.
  typedef logic [3:0] op_t;
  localparam op_t OP_FIRST_MEAN = 4'd0;
  localparam op_t OP_LAST_MEAN  = 4'd7;
  localparam op_t OP_UP         = 4'd8;
  localparam op_t OP_RIGHT      = 4'd9;
  localparam op_t OP_LEFT       = 4'd10;
  localparam op_t OP_DOWN       = 4'd11;

  // Score slots, taken from the low bits of the operation code.
  localparam logic [1:0] SC_UP    = 2'd0;
  localparam logic [1:0] SC_RIGHT = 2'd1;
  localparam logic [1:0] SC_LEFT  = 2'd2;
  localparam logic [1:0] SC_DOWN  = 2'd3;

  typedef logic [NCH-1:0][MAG_W-1:0] frame_t;

  typedef struct packed {
    logic capture;
    logic fill;
    logic div_start;
    logic div_store;
    logic update;
    logic decide;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic div_done;
    logic out_free;
  } sts_t;

  // Magnitude of a two's complement sample; the most negative value maps to 128.
  function automatic logic [MAG_W-1:0] rectify(input logic signed [SAMPLE_W-1:0] s);
    logic [MAG_W-1:0] u;
    u = s;
    if (u[MAG_W-1]) begin
      return ~u + 8'd1;
    end
    return u;
  endfunction

endpackage

>>> hdl/emgwdc_ram.sv
module emgwdc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/emgwdc_div.sv
module emgwdc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [emgwdc_pkg::DIV_W-1:0]   num_i,
  input  logic [emgwdc_pkg::DIVR_W-1:0]  den_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [emgwdc_pkg::DIV_W-1:0]   quo_o
);

  localparam int unsigned DW = emgwdc_pkg::DIV_W;
  localparam int unsigned RW = emgwdc_pkg::DIVR_W;
  localparam int unsigned CW = $clog2(DW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] den_q, den_d;

  logic [RW:0]   shifted;
  logic [RW:0]   diff;
  logic          ge;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem_q, quo_q[DW-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[RW-1:0] : shifted[RW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

endmodule

>>> hdl/emgwdc_ctrl.sv
module emgwdc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  emgwdc_pkg::sts_t  sts_i,
  output emgwdc_pkg::cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_FILL     = 7'b0000010,
    ST_MEAN     = 7'b0000100,
    ST_DIV_GO   = 7'b0001000,
    ST_DIV_WAIT = 7'b0010000,
    ST_UPDATE   = 7'b0100000,
    ST_DECIDE   = 7'b1000000
  } ctrl_state_e;

  ctrl_state_e       state_q, state_d;
  emgwdc_pkg::op_t   op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (sts_i.full) begin
            op_d    = emgwdc_pkg::OP_FIRST_MEAN;
            state_d = ST_MEAN;
          end else begin
            state_d = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_MEAN: begin
        // One channel mean is stored every cycle.
        cmd_o.div_store = 1'b1;
        if (op_q == emgwdc_pkg::OP_LAST_MEAN) begin
          state_d = ST_UPDATE;
        end else begin
          op_d = op_q + 1'b1;
        end
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (op_q == emgwdc_pkg::OP_DOWN) begin
            state_d = ST_DECIDE;
          end else begin
            op_d    = op_q + 1'b1;
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        op_d         = emgwdc_pkg::OP_UP;
        state_d      = ST_DIV_GO;
      end
      ST_DECIDE: begin
        if (sts_i.out_free) begin
          cmd_o.decide = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= emgwdc_pkg::OP_FIRST_MEAN;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

>>> hdl/emgwdc_dp.sv
module emgwdc_dp #(
  parameter int unsigned WINDOW = emgwdc_pkg::WINDOW_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  emgwdc_pkg::cmd_t                  cmd_i,
  output emgwdc_pkg::sts_t                  sts_o,
  input  emgwdc_pkg::frame_t                frame_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [emgwdc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [emgwdc_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [emgwdc_pkg::DIR_W-1:0]      direction_o,
  output logic                              decided_o
);

  localparam int unsigned NCH    = emgwdc_pkg::NCH;
  localparam int unsigned MAG_W  = emgwdc_pkg::MAG_W;
  localparam int unsigned DW     = emgwdc_pkg::DIV_W;
  localparam int unsigned RW     = emgwdc_pkg::DIVR_W;
  localparam int unsigned TW     = emgwdc_pkg::TOT_W;
  localparam int unsigned CW     = emgwdc_pkg::CFG_W;
  localparam int unsigned DRW    = emgwdc_pkg::DIR_W;
  localparam int unsigned AW     = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = $clog2(WINDOW * emgwdc_pkg::MAG_MAX + 1);

  // Floor division by the window length as a reciprocal multiplication. With
  // the shift at SUM_W plus the bits of WINDOW and the reciprocal rounded up,
  // the quotient is exact for every sum the window can hold.
  localparam int unsigned MEAN_SH = SUM_W + AW;
  localparam int unsigned RCP_W   = MEAN_SH + 1;
  localparam logic [RCP_W-1:0] MEAN_RECIP = RCP_W'(((1 << MEAN_SH) + WINDOW - 1) / WINDOW);

  // Configuration registers.
  logic [CW-1:0] thr_q, up_gain_q, right_gain_q;

  // Frame under work, window bookkeeping and per-channel sums.
  emgwdc_pkg::frame_t frame_q;
  emgwdc_pkg::frame_t old_frame;
  logic [AW-1:0]      head_q;
  logic [CNT_W-1:0]   fill_q;
  logic [SUM_W-1:0]   sum_q [NCH];
  logic [SUM_W-1:0]   sum_d [NCH];
  logic [MAG_W-1:0]   m_q   [NCH];
  logic [DW-1:0]      score_q [4];
  logic               full;

  // Channel mean of the channel named by the operation code.
  logic [SUM_W-1:0]       mean_sum;
  logic [SUM_W+RCP_W-1:0] mean_prod;
  logic [MAG_W-1:0]       mean_val;

  // Divider operands.
  logic [DW-1:0]      div_num;
  logic [RW-1:0]      div_den;
  logic [DW-1:0]      div_quo;
  logic               div_busy;
  logic               div_done;
  logic [RW-1:0]      mw    [NCH];

  // Decision.
  logic [TW-1:0]      up_s, right_s, left_s, down_s, total, limit;
  logic [DRW-1:0]     dir_d;
  logic               decided_d;
  logic [DRW-1:0]     last_dir_q;
  logic               out_valid_q;
  logic [DRW-1:0]     dir_q;
  logic               decided_q;

  assign full = (fill_q == CNT_W'(WINDOW));

  // Configuration writes; indexes beyond the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= emgwdc_pkg::RESET_REST_THRESHOLD;
      up_gain_q    <= emgwdc_pkg::RESET_UP_GAIN;
      right_gain_q <= emgwdc_pkg::RESET_RIGHT_GAIN;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        emgwdc_pkg::REG_REST_THRESHOLD: thr_q        <= cfg_data_i;
        emgwdc_pkg::REG_UP_GAIN:        up_gain_q    <= cfg_data_i;
        emgwdc_pkg::REG_RIGHT_GAIN:     right_gain_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Window store. The read of the oldest frame is issued with the capture
  // and its data holds until the update.
  emgwdc_ram #(
    .WIDTH ($bits(emgwdc_pkg::frame_t)),
    .DEPTH (WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fill | cmd_i.update),
    .waddr_i (cmd_i.fill ? fill_q[AW-1:0] : head_q),
    .wdata_i (frame_q),
    .re_i    (cmd_i.capture),
    .raddr_i (head_q),
    .rdata_o (old_frame)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      frame_q <= frame_i;
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum_d[c] = sum_q[c];
      if (cmd_i.fill) begin
        sum_d[c] = sum_q[c] + SUM_W'(frame_q[c]);
      end else if (cmd_i.update) begin
        sum_d[c] = sum_q[c] - SUM_W'(old_frame[c]) + SUM_W'(frame_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      for (int c = 0; c < NCH; c++) begin
        sum_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < NCH; c++) begin
        sum_q[c] <= sum_d[c];
      end
      if (cmd_i.fill) begin
        fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.update) begin
        head_q <= (head_q == AW'(WINDOW - 1)) ? '0 : head_q + 1'b1;
      end
    end
  end

  assign mean_sum  = sum_q[cmd_i.op[2:0]];
  assign mean_prod = {{RCP_W{1'b0}}, mean_sum} * {{SUM_W{1'b0}}, MEAN_RECIP};
  assign mean_val  = mean_prod[MEAN_SH +: MAG_W];

  // Operand selection for the shared divider.
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      mw[c] = RW'(m_q[c]);
    end
    case (cmd_i.op)
      emgwdc_pkg::OP_UP: begin
        div_num = DW'(m_q[4]) * DW'(up_gain_q);
        div_den = RW'(1) + mw[1] + mw[7];
      end
      emgwdc_pkg::OP_RIGHT: begin
        div_num = DW'(m_q[3]) * DW'(right_gain_q);
        div_den = RW'(1) + mw[7] + mw[1];
      end
      emgwdc_pkg::OP_LEFT: begin
        div_num = DW'(mw[0] + mw[7]);
        div_den = RW'(1) + mw[5];
      end
      emgwdc_pkg::OP_DOWN: begin
        div_num = DW'({1'b0, mw[0]} + {1'b0, mw[1]} + {1'b0, mw[2]});
        div_den = RW'(1) + mw[5] + mw[6];
      end
      default: begin
        div_num = '0;
        div_den = RW'(1);
      end
    endcase
  end

  emgwdc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      if (cmd_i.op[3]) begin
        score_q[cmd_i.op[1:0]] <= div_quo;
      end else begin
        m_q[cmd_i.op[2:0]] <= mean_val;
      end
    end
  end

  // Scores in Q.8; the integer quotients move up by eight bits.
  assign up_s    = TW'(score_q[emgwdc_pkg::SC_UP]);
  assign right_s = TW'(score_q[emgwdc_pkg::SC_RIGHT]);
  assign left_s  = {score_q[emgwdc_pkg::SC_LEFT][TW-9:0], 8'h00};
  assign down_s  = {score_q[emgwdc_pkg::SC_DOWN][TW-9:0], 8'h00};
  assign total   = up_s + right_s + left_s + down_s;
  assign limit   = TW'({thr_q, 8'h00});

  always_comb begin
    decided_d = 1'b1;
    if (total <= limit) begin
      dir_d = emgwdc_pkg::DIR_REST;
    end else if (up_s > right_s && up_s > left_s && up_s > down_s) begin
      dir_d = emgwdc_pkg::DIR_UP;
    end else if (left_s > right_s && left_s > up_s && left_s > down_s) begin
      dir_d = emgwdc_pkg::DIR_LEFT;
    end else if (right_s > left_s && right_s > up_s && right_s > down_s) begin
      dir_d = emgwdc_pkg::DIR_RIGHT;
    end else if (down_s > right_s && down_s > left_s && down_s > up_s) begin
      dir_d = emgwdc_pkg::DIR_DOWN;
    end else begin
      dir_d     = last_dir_q;
      decided_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_dir_q  <= emgwdc_pkg::DIR_REST;
    end else begin
      if (cmd_i.decide) begin
        out_valid_q <= 1'b1;
        last_dir_q  <= dir_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      dir_q     <= dir_d;
      decided_q <= decided_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign direction_o = dir_q;
  assign decided_o   = decided_q;

  assign sts_o.full     = full;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_decide_output_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a pending result");

  a_update_full_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update |-> full) and (cmd_i.fill |-> !full))
    else $error("window update and fill out of order");

endmodule

>>> hdl/emg_window_direction_classifier.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_stall_o  sample_ch0_i .. sample_ch7_i
// out       output     out_valid_o/out_stall_i direction_o, decided_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A request that only fills the window is captured and then written into the
// window store. Every later request runs from acceptance until its result is
// registered through eight channel means at one a cycle by reciprocal
// multiplication, the window update, four score divisions in turn through one
// shared divider that retires one quotient bit a cycle, and the decision.
// Reset is asynchronous and active low; it clears the fill count, the head
// pointer, the channel sums, the last direction and the registers to their
// defaults. The window store itself is not cleared; the fill count keeps it
// from being read before it is written. A result waits in the output register
// while out_stall_i is high; the next input request is still taken and is
// held back only when its own result is ready and the register is full.
module emg_window_direction_classifier #(
  parameter int unsigned WINDOW = emgwdc_pkg::WINDOW_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [emgwdc_pkg::SAMPLE_W-1:0] sample_ch0_i,
  input  logic signed [emgwdc_pkg::SAMPLE_W-1:0] sample_ch1_i,
  input  logic signed [emgwdc_pkg::SAMPLE_W-1:0] sample_ch2_i,
  input  logic signed [emgwdc_pkg::SAMPLE_W-1:0] sample_ch3_i,
  input  logic signed [emgwdc_pkg::SAMPLE_W-1:0] sample_ch4_i,
  input  logic signed [emgwdc_pkg::SAMPLE_W-1:0] sample_ch5_i,
  input  logic signed [emgwdc_pkg::SAMPLE_W-1:0] sample_ch6_i,
  input  logic signed [emgwdc_pkg::SAMPLE_W-1:0] sample_ch7_i,

  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [emgwdc_pkg::DIR_W-1:0]      direction_o,
  output logic                              decided_o,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [emgwdc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [emgwdc_pkg::CFG_W-1:0]      cfg_data_i
);

  // The rectified frame is what the window keeps. Each magnitude fits in
  // eight unsigned bits, including 128 from the most negative sample.
  emgwdc_pkg::frame_t frame;
  emgwdc_pkg::cmd_t   cmd;
  emgwdc_pkg::sts_t   sts;

  assign frame[0] = emgwdc_pkg::rectify(sample_ch0_i);
  assign frame[1] = emgwdc_pkg::rectify(sample_ch1_i);
  assign frame[2] = emgwdc_pkg::rectify(sample_ch2_i);
  assign frame[3] = emgwdc_pkg::rectify(sample_ch3_i);
  assign frame[4] = emgwdc_pkg::rectify(sample_ch4_i);
  assign frame[5] = emgwdc_pkg::rectify(sample_ch5_i);
  assign frame[6] = emgwdc_pkg::rectify(sample_ch6_i);
  assign frame[7] = emgwdc_pkg::rectify(sample_ch7_i);

  // The controller sequences fill, the eight means, the window update, the
  // four scores and the decision; the datapath holds the window, the sums, the scores and the registers.
  emgwdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  emgwdc_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .frame_i     (frame),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .direction_o (direction_o),
    .decided_o   (decided_o)
  );

endmodule

>>> bench/emgwdc_direction_checker.sv
module emgwdc_direction_checker #(
  parameter int unsigned WINDOW = emgwdc_pkg::WINDOW_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [emgwdc_pkg::SAMPLE_W-1:0] sample_ch0_i,
  input  logic [emgwdc_pkg::SAMPLE_W-1:0] sample_ch1_i,
  input  logic [emgwdc_pkg::SAMPLE_W-1:0] sample_ch2_i,
  input  logic [emgwdc_pkg::SAMPLE_W-1:0] sample_ch3_i,
  input  logic [emgwdc_pkg::SAMPLE_W-1:0] sample_ch4_i,
  input  logic [emgwdc_pkg::SAMPLE_W-1:0] sample_ch5_i,
  input  logic [emgwdc_pkg::SAMPLE_W-1:0] sample_ch6_i,
  input  logic [emgwdc_pkg::SAMPLE_W-1:0] sample_ch7_i,

  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [emgwdc_pkg::DIR_W-1:0]    direction_i,
  input  logic                            decided_i,

  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [emgwdc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [emgwdc_pkg::CFG_W-1:0]     cfg_data_i,

  output int                              failures_o,
  output int                              outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCH      = emgwdc_pkg::NCH;
  localparam int unsigned MAG_W    = emgwdc_pkg::MAG_W;
  localparam int unsigned SAMPLE_W = emgwdc_pkg::SAMPLE_W;
  localparam int unsigned DIR_W    = emgwdc_pkg::DIR_W;
  localparam int unsigned CFG_W    = emgwdc_pkg::CFG_W;
  localparam int unsigned PTR_W    = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W    = $clog2(WINDOW * emgwdc_pkg::MAG_MAX + 1);

  typedef struct packed {
    logic [DIR_W-1:0] direction;
    logic             decided;
  } decision_t;

  logic [NCH-1:0][SAMPLE_W-1:0] frame_in;

  logic [MAG_W-1:0] window_mags [WINDOW][NCH];
  logic [PTR_W-1:0] oldest_slot;
  logic [PTR_W-1:0] frames_seen;
  logic [SUM_W-1:0] running_sums [NCH];
  logic [DIR_W-1:0] prev_direction;
  logic [CFG_W-1:0] rest_limit;
  logic [CFG_W-1:0] up_weight;
  logic [CFG_W-1:0] right_weight;

  decision_t expected_decisions [$];
  int        mismatches;

  assign frame_in = {sample_ch7_i, sample_ch6_i, sample_ch5_i, sample_ch4_i,
                     sample_ch3_i, sample_ch2_i, sample_ch1_i, sample_ch0_i};

  function automatic logic strictly_ahead(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    return (a > b) && (a > c) && (a > d);
  endfunction

  task automatic classify_frame(input logic [NCH-1:0][SAMPLE_W-1:0] raw);
    logic [MAG_W-1:0] mag [NCH];
    logic [31:0]      mean [NCH];
    logic [31:0]      up_score;
    logic [31:0]      right_score;
    logic [31:0]      left_score;
    logic [31:0]      down_score;
    logic [31:0]      score_sum;
    decision_t        verdict;

    // Negation wraps -128 onto 8'h80, which reads as 128 unsigned.
    for (int c = 0; c < NCH; c++) begin
      mag[c] = raw[c][SAMPLE_W-1] ? MAG_W'(MAG_W'(0) - raw[c]) : MAG_W'(raw[c]);
    end

    if (frames_seen < WINDOW) begin
      for (int c = 0; c < NCH; c++) begin
        window_mags[frames_seen][c] = mag[c];
        running_sums[c] = running_sums[c] + mag[c];
      end
      frames_seen = frames_seen + 1'b1;
      oldest_slot = '0;
      return;
    end

    // Means come from the window before this frame replaces the oldest one.
    for (int c = 0; c < NCH; c++) begin
      mean[c] = 32'(running_sums[c]) / WINDOW;
    end

    if (oldest_slot >= WINDOW) begin
      oldest_slot = '0;
    end
    for (int c = 0; c < NCH; c++) begin
      running_sums[c] = running_sums[c] - window_mags[oldest_slot][c] + mag[c];
      window_mags[oldest_slot][c] = mag[c];
    end
    oldest_slot = PTR_W'((32'(oldest_slot) + 1) % WINDOW);

    up_score    = (mean[4] * 32'(up_weight)) / (32'd1 + mean[1] + mean[7]);
    right_score = (mean[3] * 32'(right_weight)) / (32'd1 + mean[7] + mean[1]);
    left_score  = ((mean[0] + mean[7]) / (32'd1 + mean[5])) << 8;
    down_score  = ((mean[0] + mean[1] + mean[2]) / (32'd1 + mean[5] + mean[6])) << 8;
    score_sum   = up_score + right_score + left_score + down_score;

    verdict.decided = 1'b1;
    if (score_sum <= (32'(rest_limit) << 8)) begin
      verdict.direction = emgwdc_pkg::DIR_REST;
    end else if (strictly_ahead(up_score, right_score, left_score, down_score)) begin
      verdict.direction = emgwdc_pkg::DIR_UP;
    end else if (strictly_ahead(left_score, right_score, up_score, down_score)) begin
      verdict.direction = emgwdc_pkg::DIR_LEFT;
    end else if (strictly_ahead(right_score, left_score, up_score, down_score)) begin
      verdict.direction = emgwdc_pkg::DIR_RIGHT;
    end else if (strictly_ahead(down_score, right_score, left_score, up_score)) begin
      verdict.direction = emgwdc_pkg::DIR_DOWN;
    end else begin
      verdict.direction = prev_direction;
      verdict.decided   = 1'b0;
    end
    prev_direction = verdict.direction;
    expected_decisions.insert(expected_decisions.size(), verdict);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decision_t want;
    if (!rst_ni) begin
      frames_seen    = '0;
      oldest_slot    = '0;
      prev_direction = emgwdc_pkg::DIR_REST;
      rest_limit     = emgwdc_pkg::RESET_REST_THRESHOLD;
      up_weight      = emgwdc_pkg::RESET_UP_GAIN;
      right_weight   = emgwdc_pkg::RESET_RIGHT_GAIN;
      for (int c = 0; c < NCH; c++) begin
        running_sums[c] = '0;
      end
      expected_decisions.delete();
      mismatches     = 0;
      failures_o    <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_decisions.size() == 0) begin
          $error("result with no decision pending: direction %0d, decided %0d",
                 direction_i, decided_i);
          mismatches++;
        end else begin
          want = expected_decisions.pop_front();
          if (direction_i !== want.direction) begin
            $error("direction: expected %0d, got %0d", want.direction, direction_i);
            mismatches++;
          end
          if (decided_i !== want.decided) begin
            $error("decided: expected %0d, got %0d", want.decided, decided_i);
            mismatches++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          emgwdc_pkg::REG_REST_THRESHOLD: rest_limit   = cfg_data_i;
          emgwdc_pkg::REG_UP_GAIN:        up_weight    = cfg_data_i;
          emgwdc_pkg::REG_RIGHT_GAIN:     right_weight = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        classify_frame(frame_in);
      end

      failures_o    <= mismatches;
      outstanding_o <= expected_decisions.size();
    end
  end

endmodule

>>> bench/emg_window_direction_classifier_tb.sv
// Stimulus side of the classifier bench. The checker instance beside the block
// predicts every decision and counts mismatches; this module only produces
// requests, register writes, output back-pressure and a watchdog, then calls the verdict.
module emg_window_direction_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW         = emgwdc_pkg::WINDOW_DEF;
  localparam int unsigned NCH            = emgwdc_pkg::NCH;
  localparam int unsigned SAMPLE_W       = emgwdc_pkg::SAMPLE_W;
  localparam int unsigned CFG_W          = emgwdc_pkg::CFG_W;
  localparam int unsigned CFG_IDX_W      = emgwdc_pkg::CFG_IDX_W;
  localparam int unsigned DIR_W          = emgwdc_pkg::DIR_W;
  localparam int unsigned MAG_MAX        = emgwdc_pkg::MAG_MAX;
  localparam int          CLK_PERIOD     = 10;
  localparam int          MAX_GAP        = 11;
  localparam int          DIRECTED_ITEMS = 25;
  localparam int          PHASES         = 8;
  localparam int          ITEMS_PER_RUN  = 78;
  // Long enough to cover a whole scoring request completely.
  localparam int          SETTLE_CYCLES  = 300;
  // Long enough for the output register and the next result to both fill up.
  localparam int          LONG_HOLD      = 2000;
  localparam int          CYCLE_LIMIT    = 1000000;

  // Index 3 addresses no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [SAMPLE_W-1:0] MOST_NEGATIVE = 8'h80;
  localparam logic [SAMPLE_W-1:0] MOST_POSITIVE = 8'h7f;
  localparam logic [SAMPLE_W-1:0] MINUS_ONE     = 8'hff;

  typedef logic [NCH-1:0][SAMPLE_W-1:0] raw_frame_t;

  // Shapes of channel activity used by the random bursts. Each one but
  // PROFILE_FREE steers the window means toward one outcome so that every
  // direction, rest and ties show up once a burst has filled most of the window.
  typedef enum int {
    PROFILE_REST,
    PROFILE_UP,
    PROFILE_RIGHT,
    PROFILE_LEFT,
    PROFILE_DOWN,
    PROFILE_FLAT,
    PROFILE_FREE
  } profile_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  raw_frame_t           offered   = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DIR_W-1:0]     direction;
  logic                 decided;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int                   failures;
  int                   outstanding;
  int                   cycle_count = 0;
  int                   tx_max_gap  = MAX_GAP;
  int                   rx_max_gap  = MAX_GAP;

  always #(CLK_PERIOD / 2) clk = ~clk;

  emg_window_direction_classifier #(
    .WINDOW(WINDOW)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sample_ch0_i (offered[0]),
    .sample_ch1_i (offered[1]),
    .sample_ch2_i (offered[2]),
    .sample_ch3_i (offered[3]),
    .sample_ch4_i (offered[4]),
    .sample_ch5_i (offered[5]),
    .sample_ch6_i (offered[6]),
    .sample_ch7_i (offered[7]),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .direction_o  (direction),
    .decided_o    (decided),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  emgwdc_direction_checker #(
    .WINDOW(WINDOW)
  ) checker_inst (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .sample_ch0_i  (offered[0]),
    .sample_ch1_i  (offered[1]),
    .sample_ch2_i  (offered[2]),
    .sample_ch3_i  (offered[3]),
    .sample_ch4_i  (offered[4]),
    .sample_ch5_i  (offered[5]),
    .sample_ch6_i  (offered[6]),
    .sample_ch7_i  (offered[7]),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .direction_i   (direction),
    .decided_i     (decided),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .failures_o    (failures),
    .outstanding_o (outstanding)
  );

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one frame after a random idle gap and returns at the edge that
  // accepts it. Valid stays high afterwards, so back-to-back requests never
  // drop it; the payload only changes once the previous request is taken.
  task automatic offer_frame(input raw_frame_t frame);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    offered  <= frame;
    do @(posedge clk); while (in_stall);
  endtask

  // Writes all three registers plus the unused index in one burst of write
  // requests. Valid stays high between writes and drops after the last one.
  task automatic apply_setting(input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] up,
                               input logic [CFG_W-1:0] right);
    logic [CFG_W-1:0] values [4];
    values[emgwdc_pkg::REG_REST_THRESHOLD] = limit;
    values[emgwdc_pkg::REG_UP_GAIN]        = up;
    values[emgwdc_pkg::REG_RIGHT_GAIN]     = right;
    values[REG_UNUSED]                     = CFG_W'($urandom_range(0, 1023));
    for (int r = 0; r < 4; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data  <= values[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Stops offering and waits until every predicted decision has come back.
  // Window-filling requests give no result, so a settle time follows in case
  // one is still being absorbed. The outstanding count is registered, hence
  // the edge before the first look at it.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side. Before each result the receiver stalls for a random number
  // of cycles, then takes the next one. Twice during the run it holds off for
  // a long stretch while the sender keeps going, so that the block's output
  // register and its next result both fill and the input side stalls.
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    forever begin
      if (taken == 30 || taken == 350) begin
        hold = LONG_HOLD;
      end else begin
        hold = $urandom_range(0, rx_max_gap);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : request_source
    raw_frame_t       frame;
    logic [CFG_W-1:0] limit;
    logic [CFG_W-1:0] up;
    logic [CFG_W-1:0] right;
    logic [SAMPLE_W-1:0] hot;
    profile_e         kind;
    int               levels [NCH];
    int               burst;
    int               sent;
    int               spread;
    int               mag;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < PHASES; phase++) begin
      // Each run uses its own register setting, extremes included, and its
      // own idling mix: some runs have no gaps on one side or on both.
      case (phase)
        0: begin
          limit = emgwdc_pkg::RESET_REST_THRESHOLD;
          up    = emgwdc_pkg::RESET_UP_GAIN;
          right = emgwdc_pkg::RESET_RIGHT_GAIN;
          tx_max_gap = MAX_GAP; rx_max_gap = MAX_GAP;
        end
        1: begin
          // Zero gains leave only left and down, so ties are common.
          limit = '0; up = '0; right = '0;
          tx_max_gap = 0; rx_max_gap = MAX_GAP;
        end
        2: begin
          limit = '1; up = '1; right = '1;
          tx_max_gap = MAX_GAP; rx_max_gap = 0;
        end
        3: begin
          // Equal gains make the up and right scores tie on equal means.
          limit = '0; up = CFG_W'(256); right = CFG_W'(256);
          tx_max_gap = 0; rx_max_gap = 0;
        end
        5: begin
          limit = CFG_W'(1); up = '1; right = '0;
          tx_max_gap = MAX_GAP; rx_max_gap = MAX_GAP;
        end
        default: begin
          limit = CFG_W'($urandom_range(0, 1023));
          up    = CFG_W'($urandom_range(0, 1023));
          right = CFG_W'($urandom_range(0, 1023));
          tx_max_gap = MAX_GAP; rx_max_gap = MAX_GAP;
        end
      endcase
      apply_setting(limit, up, right);

      // Directed opening: sample extremes at the start of the fill, then
      // frames that each favor one direction, which run on into scoring.
      if (phase == 0) begin
        for (int k = 0; k < DIRECTED_ITEMS; k++) begin
          case (k)
            0: frame = {NCH{MOST_NEGATIVE}};
            1: frame = {NCH{MOST_POSITIVE}};
            2: frame = '0;
            3: frame = {NCH{MINUS_ONE}};
            4: frame = {(NCH / 2){MOST_POSITIVE, MOST_NEGATIVE}};
            default: begin
              hot = k[0] ? SAMPLE_W'(-90) : SAMPLE_W'(90);
              for (int c = 0; c < NCH; c++) begin
                frame[c] = SAMPLE_W'(1);
              end
              case (k % 4)
                0: frame[4] = hot;
                1: frame[3] = hot;
                2: begin
                  frame[0] = hot;
                  frame[7] = hot;
                end
                default: begin
                  frame[0] = hot;
                  frame[1] = hot;
                  frame[2] = hot;
                end
              endcase
            end
          endcase
          offer_frame(frame);
        end
      end

      // Random bursts: each one picks a profile and holds it long enough to
      // pull the window means toward it, with jitter on every sample and
      // the odd frame of pure noise mixed in.
      sent = 0;
      while (sent < ITEMS_PER_RUN) begin
        kind  = profile_e'($urandom_range(0, int'(PROFILE_FREE)));
        burst = $urandom_range(4, 30);
        for (int c = 0; c < NCH; c++) begin
          levels[c] = $urandom_range(0, 3);
        end
        case (kind)
          PROFILE_UP:    levels[4] = $urandom_range(24, MAG_MAX);
          PROFILE_RIGHT: levels[3] = $urandom_range(24, MAG_MAX);
          PROFILE_LEFT: begin
            levels[0] = $urandom_range(24, MAG_MAX);
            levels[7] = $urandom_range(24, MAG_MAX);
            levels[5] = 0;
          end
          PROFILE_DOWN: begin
            levels[0] = $urandom_range(24, MAG_MAX);
            levels[1] = $urandom_range(24, MAG_MAX);
            levels[2] = $urandom_range(24, MAG_MAX);
            levels[5] = 0;
            levels[6] = 0;
          end
          PROFILE_FLAT: begin
            levels[0] = $urandom_range(0, MAG_MAX);
            for (int c = 1; c < NCH; c++) begin
              levels[c] = levels[0];
            end
          end
          PROFILE_FREE: begin
            for (int c = 0; c < NCH; c++) begin
              levels[c] = $urandom_range(0, MAG_MAX);
            end
          end
          default: ;
        endcase

        for (int k = 0; k < burst && sent < ITEMS_PER_RUN; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            frame = {$urandom(), $urandom()};
          end else begin
            for (int c = 0; c < NCH; c++) begin
              spread = levels[c] / 4;
              mag = levels[c] + int'($urandom_range(0, 2 * spread)) - spread;
              if (mag < 0) mag = 0;
              if (mag >= MAG_MAX) begin
                // A full-scale magnitude only exists as the most negative code.
                frame[c] = MOST_NEGATIVE;
              end else if ($urandom_range(0, 1) == 1) begin
                frame[c] = SAMPLE_W'(-mag);
              end else begin
                frame[c] = SAMPLE_W'(mag);
              end
            end
          end
          offer_frame(frame);
          sent++;
        end
      end

      // The sender pauses here until every expected decision has arrived,
      // which also makes the next register write safe.
      wait_until_idle();
    end

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
